// ----- src/ptt_pkg.sv -----
// Shared types and constants for the periodic timer slot table.
package ptt_pkg;

   localparam int SLOTS = 16;
   localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SLOT_W = 6;
   localparam int TICK_W = 32;
   localparam int ACTION_W = 3;

   typedef logic [SLOT_IDX_W-1:0] idx_type;
   typedef logic [SLOT_W-1:0] slot_id_type;
   typedef logic [TICK_W-1:0] tick_type;
   typedef logic [ACTION_W-1:0] action_code_type;

   localparam idx_type LAST_IDX = idx_type'(SLOTS - 1);
   localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(SLOTS);

   localparam action_code_type ACT_CREATE = 3'd0;
   localparam action_code_type ACT_DELETE = 3'd1;
   localparam action_code_type ACT_SET_STATE = 3'd2;
   localparam action_code_type ACT_SET_PERIOD = 3'd3;
   localparam action_code_type ACT_POLL = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      idx_type  idx;
      logic     we_active;
      logic     active;
      logic     we_enabled;
      logic     enabled;
      logic     we_period;
      tick_type period;
      logic     we_deadline;
      tick_type deadline;
   } slot_wr_type;

   typedef struct packed {
      logic     active;
      logic     enabled;
      tick_type period;
      tick_type deadline;
   } slot_rd_type;

endpackage

// ----- src/ptt_slot_store.sv -----
// Slot table storage: active and enable marks, period and deadline per slot.
module ptt_slot_store (
   input  logic                clock,
   input  logic                reset,
   input  ptt_pkg::idx_type     rd_idx,
   output ptt_pkg::slot_rd_type rd,
   input  ptt_pkg::slot_wr_type wr
);

   logic [ptt_pkg::SLOTS-1:0] active_ff;
   logic [ptt_pkg::SLOTS-1:0] enabled_ff;
   ptt_pkg::tick_type         period_ff [ptt_pkg::SLOTS];
   ptt_pkg::tick_type         deadline_ff [ptt_pkg::SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         enabled_ff <= '0;
      end else begin
         if (wr.we_active) begin
            active_ff[wr.idx] <= wr.active;
         end
         if (wr.we_enabled) begin
            enabled_ff[wr.idx] <= wr.enabled;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.we_period) begin
         period_ff[wr.idx] <= wr.period;
      end
      if (wr.we_deadline) begin
         deadline_ff[wr.idx] <= wr.deadline;
      end
   end

   always_comb begin
      rd.active = active_ff[rd_idx];
      rd.enabled = enabled_ff[rd_idx];
      rd.period = period_ff[rd_idx];
      rd.deadline = deadline_ff[rd_idx];
   end

endmodule

// ----- src/ptt_arith.sv -----
// Shared adder and deadline comparator used on every scan step.
module ptt_arith (
   input  ptt_pkg::tick_type now_tick,
   input  ptt_pkg::tick_type addend,
   input  ptt_pkg::tick_type deadline,
   output ptt_pkg::tick_type sum,
   output logic              due
);

   assign sum = now_tick + addend;
   assign due = (now_tick >= deadline);

endmodule

// ----- src/periodic_task_timer_table.sv -----
// Top level of the periodic timer slot table: sequencer and result register.
// Create and poll scan one slot per cycle while the reply output can take a reply:
// accept, then a scan of up to SLOTS slots, then the flush state for poll.
// Delete, set state, set period and unknown actions go through the single-slot state.
// One item at a time; the scan loop over the single slot read port sets the rate.
// Synchronous active-high reset clears all slot marks and the control state.
module periodic_task_timer_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [5:0]  req_slot,
   input  logic [31:0] req_now_tick,
   input  logic [31:0] req_period_ticks,
   input  logic [31:0] req_delay_ticks,
   input  logic        req_enable,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [5:0]  rsp_slot_out,
   output logic        rsp_fired,
   output logic        rsp_last
);

   ptt_pkg::state_type       state_ff, state_in;
   ptt_pkg::action_code_type action_ff;
   ptt_pkg::slot_id_type     slot_ff;
   ptt_pkg::tick_type        now_ff, period_ff, delay_ff;
   logic                     enable_ff;
   ptt_pkg::idx_type         idx_ff, idx_in;
   logic                     pend_valid_ff, pend_valid_in;
   ptt_pkg::idx_type         pend_idx_ff, pend_idx_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_status_ff;
   ptt_pkg::slot_id_type rsp_slot_ff;
   logic                 rsp_fired_ff, rsp_last_ff;

   logic                 emit;
   logic                 emit_status, emit_fired, emit_last;
   ptt_pkg::slot_id_type emit_slot;

   ptt_pkg::idx_type     rd_idx;
   ptt_pkg::slot_rd_type rd;
   ptt_pkg::slot_wr_type wr;
   ptt_pkg::tick_type    addend, sum;
   logic                 due;

   logic accept, out_free, is_last_idx, is_create, slot_ok, usable;
   logic create_done, due_hit, poll_stall;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ptt_pkg::ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_last_idx = (idx_ff == ptt_pkg::LAST_IDX);
   assign is_create = (action_ff == ptt_pkg::ACT_CREATE);
   assign slot_ok = ({1'b0, slot_ff} < ptt_pkg::SLOT_LIMIT);
   assign usable = slot_ok && rd.active;
   assign create_done = out_free && (!rd.active || is_last_idx);
   assign due_hit = rd.active && rd.enabled && due;
   assign poll_stall = due_hit && pend_valid_ff && !out_free;

   assign rd_idx = (state_ff == ptt_pkg::ST_SCAN) ? idx_ff
                                                  : slot_ff[ptt_pkg::SLOT_IDX_W-1:0];
   assign addend = is_create ? delay_ff : rd.period;

   ptt_slot_store u_store (
      .clock  (clock),
      .reset  (reset),
      .rd_idx (rd_idx),
      .rd     (rd),
      .wr     (wr)
   );

   ptt_arith u_arith (
      .now_tick (now_ff),
      .addend   (addend),
      .deadline (rd.deadline),
      .sum      (sum),
      .due      (due)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptt_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_action inside {ptt_pkg::ACT_CREATE, ptt_pkg::ACT_POLL}) begin
                  state_in = ptt_pkg::ST_SCAN;
               end else begin
                  state_in = ptt_pkg::ST_SINGLE;
               end
            end
         end
         ptt_pkg::ST_SINGLE: begin
            if (out_free) begin
               state_in = ptt_pkg::ST_IDLE;
            end
         end
         ptt_pkg::ST_SCAN: begin
            if (is_create) begin
               if (create_done) begin
                  state_in = ptt_pkg::ST_IDLE;
               end
            end else if (!poll_stall && is_last_idx) begin
               state_in = ptt_pkg::ST_FLUSH;
            end
         end
         ptt_pkg::ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ptt_pkg::ST_IDLE;
            end
         end
         default: state_in = ptt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      emit = 1'b0;
      emit_status = 1'b0;
      emit_slot = '0;
      emit_fired = 1'b0;
      emit_last = 1'b1;
      idx_in = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in = pend_idx_ff;
      wr = '0;
      wr.idx = rd_idx;
      case (state_ff)
         ptt_pkg::ST_IDLE: begin
            idx_in = '0;
            pend_valid_in = 1'b0;
         end
         ptt_pkg::ST_SINGLE: begin
            if (out_free) begin
               emit = 1'b1;
               emit_status = !usable;
               case (action_ff)
                  ptt_pkg::ACT_DELETE: begin
                     wr.we_active = usable;
                     wr.we_enabled = usable;
                  end
                  ptt_pkg::ACT_SET_STATE: begin
                     wr.we_enabled = usable;
                     wr.enabled = enable_ff;
                  end
                  ptt_pkg::ACT_SET_PERIOD: begin
                     wr.we_period = usable;
                     wr.period = period_ff;
                  end
                  default: emit_status = 1'b1;
               endcase
            end
         end
         ptt_pkg::ST_SCAN: begin
            if (is_create) begin
               if (create_done) begin
                  emit = 1'b1;
                  if (!rd.active) begin
                     emit_slot = ptt_pkg::slot_id_type'(idx_ff);
                     wr.we_active = 1'b1;
                     wr.active = 1'b1;
                     wr.we_enabled = 1'b1;
                     wr.we_period = 1'b1;
                     wr.period = period_ff;
                     wr.we_deadline = 1'b1;
                     wr.deadline = sum;
                  end else begin
                     emit_status = 1'b1;
                  end
               end else if (out_free) begin
                  idx_in = idx_ff + 1'b1;
               end
            end else if (!poll_stall) begin
               if (due_hit) begin
                  emit = pend_valid_ff;
                  emit_slot = ptt_pkg::slot_id_type'(pend_idx_ff);
                  emit_fired = 1'b1;
                  emit_last = 1'b0;
                  pend_valid_in = 1'b1;
                  pend_idx_in = idx_ff;
                  wr.we_deadline = 1'b1;
                  wr.deadline = sum;
               end
               if (!is_last_idx) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ptt_pkg::ST_FLUSH: begin
            if (pend_valid_ff && out_free) begin
               emit = 1'b1;
               emit_slot = ptt_pkg::slot_id_type'(pend_idx_ff);
               emit_fired = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pend_idx_ff <= pend_idx_in;
      if (accept) begin
         action_ff <= req_action;
         slot_ff <= req_slot;
         now_ff <= req_now_tick;
         period_ff <= req_period_ticks;
         delay_ff <= req_delay_ticks;
         enable_ff <= req_enable;
      end
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_slot_ff <= emit_slot;
         rsp_fired_ff <= emit_fired;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot_out = rsp_slot_ff;
   assign rsp_fired = rsp_fired_ff;
   assign rsp_last = rsp_last_ff;

endmodule

// ----- sim/timer_table_checker.sv -----
// Checker for the periodic timer slot table: predicts each reply and compares transfers.
module timer_table_checker
   import ptt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [5:0]  req_slot,
   input  logic [31:0] req_now_tick,
   input  logic [31:0] req_period_ticks,
   input  logic [31:0] req_delay_ticks,
   input  logic        req_enable,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_status,
   input  logic [5:0]  rsp_slot_out,
   input  logic        rsp_fired,
   input  logic        rsp_last,
   output int          mismatch_count,
   output int          awaited_count
);

   typedef struct packed {
      logic        status;
      slot_id_type slot_out;
      logic        fired;
      logic        last;
   } reply_type;

   logic      slot_on     [SLOTS];
   logic      slot_run    [SLOTS];
   tick_type  slot_reload [SLOTS];
   tick_type  slot_due    [SLOTS];
   reply_type awaited_replies[$];
   int        errors = 0;

   function automatic reply_type make_reply(logic status, slot_id_type id, logic fired,
                                            logic last);
      reply_type r;
      r.status = status;
      r.slot_out = id;
      r.fired = fired;
      r.last = last;
      return r;
   endfunction

   function automatic void step_timer_table(action_code_type act, slot_id_type id,
                                            tick_type now, tick_type period,
                                            tick_type delay, logic en);
      reply_type   fired_list[$];
      int unsigned k;
      logic        usable;
      logic        found;
      k = id;
      usable = (k < SLOTS) ? slot_on[k] : 1'b0;
      found = 1'b0;
      case (act)
         ACT_CREATE: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!found && !slot_on[i]) begin
                  slot_reload[i] = period;
                  slot_due[i] = now + delay;
                  slot_on[i] = 1'b1;
                  slot_run[i] = 1'b0;
                  awaited_replies.push_back(make_reply(1'b0, slot_id_type'(i), 1'b0, 1'b1));
                  found = 1'b1;
               end
            end
            if (!found) begin
               awaited_replies.push_back(make_reply(1'b1, '0, 1'b0, 1'b1));
            end
         end
         ACT_DELETE, ACT_SET_STATE, ACT_SET_PERIOD: begin
            if (!usable) begin
               awaited_replies.push_back(make_reply(1'b1, '0, 1'b0, 1'b1));
            end else begin
               if (act == ACT_DELETE) begin
                  slot_on[k] = 1'b0;
                  slot_run[k] = 1'b0;
               end else if (act == ACT_SET_STATE) begin
                  slot_run[k] = en;
               end else begin
                  slot_reload[k] = period;
               end
               awaited_replies.push_back(make_reply(1'b0, '0, 1'b0, 1'b1));
            end
         end
         ACT_POLL: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_on[i] && slot_run[i] && now >= slot_due[i]) begin
                  fired_list.push_back(make_reply(1'b0, slot_id_type'(i), 1'b1, 1'b0));
                  slot_due[i] = now + slot_reload[i];
               end
            end
            if (fired_list.size() > 0) begin
               fired_list[fired_list.size() - 1].last = 1'b1;
            end
            foreach (fired_list[j]) begin
               awaited_replies.push_back(fired_list[j]);
            end
         end
         default: begin
            awaited_replies.push_back(make_reply(1'b1, '0, 1'b0, 1'b1));
         end
      endcase
   endfunction

   function automatic void compare_field(string name, logic [5:0] want, logic [5:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   function automatic void check_reply();
      reply_type want;
      if (awaited_replies.size() == 0) begin
         $display("%0t: reply transfer with none expected: status %0d slot %0d fired %0d last %0d",
                  $time, rsp_status, rsp_slot_out, rsp_fired, rsp_last);
         errors++;
         return;
      end
      want = awaited_replies.pop_front();
      compare_field("status", 6'(want.status), 6'(rsp_status));
      compare_field("slot_out", want.slot_out, rsp_slot_out);
      compare_field("fired", 6'(want.fired), 6'(rsp_fired));
      compare_field("last", 6'(want.last), 6'(rsp_last));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_on[i] = 1'b0;
            slot_run[i] = 1'b0;
            slot_reload[i] = '0;
            slot_due[i] = '0;
         end
         awaited_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_reply();
         end
         if (req_valid && req_ready) begin
            step_timer_table(action_code_type'(req_action), req_slot, req_now_tick,
                             req_period_ticks, req_delay_ticks, req_enable);
         end
      end
      mismatch_count <= errors;
      awaited_count <= awaited_replies.size();
   end

endmodule

// ----- sim/tb_periodic_task_timer_table.sv -----
// Testbench top for the periodic timer slot table: clock, reset, stimulus and verdict.
module tb_periodic_task_timer_table;
   import ptt_pkg::*;

   localparam int RANDOM_ITEMS = 390;
   localparam int CALM_ITEMS = 60;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int END_CYCLES = 60;
   localparam int STALL_LIMIT = 2000;
   localparam action_code_type ACT_FIRST_UNUSED = ACT_POLL + 3'd1;
   localparam action_code_type ACT_LAST_UNUSED = action_code_type'((1 << ACTION_W) - 1);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_action = '0;
   logic [5:0]  req_slot = '0;
   logic [31:0] req_now_tick = '0;
   logic [31:0] req_period_ticks = '0;
   logic [31:0] req_delay_ticks = '0;
   logic        req_enable = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_status;
   logic [5:0]  rsp_slot_out;
   logic        rsp_fired;
   logic        rsp_last;

   int       mismatch_count;
   int       awaited_count;
   int       quiet_cycles = 0;
   logic     idle_on = 1'b0;
   logic     long_hold = 1'b0;
   tick_type tick_now = '0;

   always #4 clock = ~clock;

   periodic_task_timer_table u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_slot         (req_slot),
      .req_now_tick     (req_now_tick),
      .req_period_ticks (req_period_ticks),
      .req_delay_ticks  (req_delay_ticks),
      .req_enable       (req_enable),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_fired        (rsp_fired),
      .rsp_last         (rsp_last)
   );

   timer_table_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_slot         (req_slot),
      .req_now_tick     (req_now_tick),
      .req_period_ticks (req_period_ticks),
      .req_delay_ticks  (req_delay_ticks),
      .req_enable       (req_enable),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_fired        (rsp_fired),
      .rsp_last         (rsp_last),
      .mismatch_count   (mismatch_count),
      .awaited_count    (awaited_count)
   );

   task automatic send_item(action_code_type act, slot_id_type id, tick_type now,
                            tick_type period, tick_type delay, logic en);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_slot <= id;
      req_now_tick <= now;
      req_period_ticks <= period;
      req_delay_ticks <= delay;
      req_enable <= en;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
   endtask

   task automatic random_item();
      int              pick;
      action_code_type act;
      slot_id_type     id;
      tick_type        period;
      tick_type        delay;
      logic            en;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 4) == 0) begin
         id = slot_id_type'($urandom_range(0, 63));
      end else begin
         id = slot_id_type'($urandom_range(0, SLOTS - 1));
      end
      if ($urandom_range(0, 49) == 0) begin
         tick_now = $urandom();
      end else begin
         tick_now = tick_now + tick_type'($urandom_range(0, 24));
      end
      period = ($urandom_range(0, 9) == 0) ? tick_type'($urandom()) :
                                             tick_type'($urandom_range(0, 40));
      delay = ($urandom_range(0, 9) == 0) ? tick_type'($urandom()) :
                                            tick_type'($urandom_range(0, 40));
      en = ($urandom_range(0, 3) != 0);
      if (pick < 22) begin
         act = ACT_CREATE;
      end else if (pick < 32) begin
         act = ACT_DELETE;
      end else if (pick < 52) begin
         act = ACT_SET_STATE;
      end else if (pick < 62) begin
         act = ACT_SET_PERIOD;
      end else if (pick < 96) begin
         act = ACT_POLL;
      end else begin
         act = action_code_type'($urandom_range(int'(ACT_FIRST_UNUSED), int'(ACT_LAST_UNUSED)));
      end
      send_item(act, id, tick_now, period, delay, en);
   endtask

   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_item(ACT_POLL, 6'd0, '0, '0, '0, 1'b0);
      send_item(ACT_CREATE, 6'd9, '0, '0, '0, 1'b0);
      send_item(ACT_SET_STATE, 6'd0, '0, '0, '0, 1'b1);
      send_item(ACT_POLL, 6'd0, '0, '0, '0, 1'b0);
      send_item(ACT_CREATE, 6'd0, '1, '1, '1, 1'b1);
      send_item(ACT_SET_STATE, 6'd1, '0, '0, '0, 1'b1);
      send_item(ACT_POLL, 6'd63, '1, '0, '0, 1'b0);
      send_item(ACT_SET_PERIOD, 6'd0, '0, 32'd5, '0, 1'b0);
      send_item(ACT_SET_STATE, 6'd1, '0, '0, '0, 1'b0);
      send_item(ACT_POLL, 6'd0, '1, '0, '0, 1'b0);
      send_item(ACT_DELETE, 6'd0, '0, '0, '0, 1'b0);
      send_item(ACT_DELETE, 6'd0, '0, '0, '0, 1'b0);
      send_item(ACT_SET_STATE, 6'd63, '0, '0, '0, 1'b1);
      send_item(ACT_SET_PERIOD, slot_id_type'(SLOTS), '0, '1, '0, 1'b0);
      send_item(ACT_SET_PERIOD, 6'd5, '0, '1, '0, 1'b0);
      send_item(ACT_DELETE, slot_id_type'(SLOTS), '0, '0, '0, 1'b0);
      for (int a = int'(ACT_FIRST_UNUSED); a <= int'(ACT_LAST_UNUSED); a++) begin
         send_item(action_code_type'(a), 6'd1, '0, '0, '0, 1'b0);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n >= RANDOM_ITEMS - CALM_ITEMS) begin
            idle_on = 1'b0;
         end else if (n % 40 == 0) begin
            idle_on = ($urandom_range(0, 3) != 0);
         end
         if (n == 120) begin
            long_hold = 1'b1;
         end
         if (n == 240) begin
            drain();
         end
         random_item();
      end

      drain();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
